@@ hw/rtl/clep_pkg.sv @@
// clep_pkg: shared types, constants and pointer helpers for the console line editor
// depends on nothing; imported by every module of the block except clep_ram
`default_nettype none

package clep_pkg;

  localparam int BUF_DEPTH = 128;
  localparam int ADDR_W    = $clog2(BUF_DEPTH);
  localparam int PTR_W     = $clog2(2 * BUF_DEPTH);
  localparam int CNT_W     = (PTR_W > 8) ? PTR_W : 8;

  localparam logic [PTR_W-1:0] PTR_MAX   = PTR_W'(2 * BUF_DEPTH - 1);
  localparam logic [PTR_W-1:0] PTR_DEPTH = PTR_W'(BUF_DEPTH);

  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_EOF  = 8'h04;
  localparam logic [7:0] CH_BS   = 8'h08;
  localparam logic [7:0] CH_NL   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_DUMP = 8'h10;
  localparam logic [7:0] CH_KILL = 8'h15;
  localparam logic [7:0] CH_DEL  = 8'h7F;

  localparam logic [2:0] RS_NONE      = 3'd0;
  localparam logic [2:0] RS_EMPTY     = 3'd1;
  localparam logic [2:0] RS_BYTE      = 3'd2;
  localparam logic [2:0] RS_NEWLINE   = 3'd3;
  localparam logic [2:0] RS_EOF_TAKEN = 3'd4;
  localparam logic [2:0] RS_EOF_KEPT  = 3'd5;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_DUMP,
    OP_KILL,
    OP_ERASE,
    OP_STORE,
    OP_READ
  } op_t;

  // classified item passed from front to back
  typedef struct packed {
    op_t        op;
    logic [7:0] ch;
    logic       first;
  } item_t;

  typedef struct packed {
    logic       echo_valid;
    logic [7:0] echo_char;
    logic [7:0] erase_count;
    logic       line_ready;
    logic       dump_request;
    logic [2:0] read_status;
    logic [7:0] read_char;
  } res_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_MAX) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_MAX : p - PTR_W'(1);
  endfunction

  function automatic logic [ADDR_W-1:0] ptr_slot(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] s;
    s = (p >= PTR_DEPTH) ? p - PTR_DEPTH : p;
    return s[ADDR_W-1:0];
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dist(input logic [PTR_W-1:0] a,
                                                input logic [PTR_W-1:0] b);
    logic [PTR_W:0] d;
    d = (a >= b) ? {1'b0, a} - {1'b0, b}
                 : {1'b0, a} + (PTR_W+1)'(2 * BUF_DEPTH) - {1'b0, b};
    return d[PTR_W-1:0];
  endfunction

  function automatic logic [7:0] sat8(input logic [CNT_W-1:0] c);
    return (c > CNT_W'(255)) ? 8'hFF : c[7:0];
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/console_line_editor.sv @@
// console_line_editor: top level of the canonical console line editor
// depends on clep_pkg, clep_front, clep_queue, clep_back (and clep_ram below it)
`default_nettype none

// Canonical terminal line editor. Every input item (a received character or
// a one-byte read request) gives exactly one result item. Received characters
// go into a 128-byte ring with read, commit and edit pointers; carriage return
// is stored and echoed as newline, NUL is ignored, and a character is dropped
// without echo while the ring is full. Backspace and delete erase one
// uncommitted character; control-U erases back to the last newline and
// reports the count, which the consumer turns into backspace, space,
// backspace per character. Newline, control-D or a full ring commits the
// line and raises line_ready. Control-P raises dump_request. A read pops one
// committed byte; control-D is consumed only when it is the first byte of
// a read call. Timing: a front register classifies each item and hands it
// through a two-entry queue to the back end, which owns the pointers and the
// line store ram (one port of each kind, registered read). In the back end a
// store, erase, dump or NUL finishes in the idle state, a read of a committed
// byte passes a read state to get the registered ram data, and control-U
// alternates an address state and a check state per erased character,
// since each step back needs one ram read before deciding to continue.
// An item passes the front register and a queue slot before it reaches the
// back end, and each result is registered before it is offered.
// The result register frees the back end as soon as a result is taken,
// and the queue lets new items enter while a result waits.

module console_line_editor import clep_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [7:0] rx_char, [8] read_first, rest zero
  input  wire logic        in_tuser,   // [0] req_type
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [7:0] echo_char, [15:8] erase_count,
                                       // [16] line_ready, [17] dump_request,
                                       // [25:18] read_char, rest zero
  output logic [3:0]       out_tuser   // [0] echo_valid, [3:1] read_status
);

  // front to queue
  logic  fq_valid, fq_ready;
  item_t fq_item;
  // queue to back
  logic  qb_valid, qb_ready;
  item_t qb_item;
  // back result
  res_t  res;

  clep_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (fq_valid),
    .q_ready   (fq_ready),
    .q_item    (fq_item)
  );

  clep_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_item  (fq_item),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_item   (qb_item)
  );

  clep_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (qb_valid),
    .q_ready   (qb_ready),
    .q_item    (qb_item),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  // pack result fields, lowest field in lowest bits
  assign out_tdata = {6'd0, res.read_char, res.dump_request, res.line_ready,
                      res.erase_count, res.echo_char};
  assign out_tuser = {res.read_status, res.echo_valid};

endmodule

`default_nettype wire

@@ hw/rtl/clep_ram.sv @@
// clep_ram: generic single write port ram with registered read
// depends on nothing
`default_nettype none

module clep_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ hw/rtl/clep_front.sv @@
// clep_front: accepts input items and classifies them into editor operations
// depends on clep_pkg
`default_nettype none

module clep_front import clep_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,
  input  wire logic        in_tuser,
  output logic             q_valid,
  input  wire logic        q_ready,
  output item_t            q_item
);

  logic  valid_r, valid_nxt;
  item_t item_r, item_nxt;
  logic  accept;

  function automatic item_t classify(input logic rd, input logic [7:0] c,
                                     input logic first);
    item_t it;
    it.ch    = c;
    it.first = first;
    if (rd) begin
      it.op = OP_READ;
    end else begin
      unique case (c) inside
        CH_NUL:          it.op = OP_NOP;
        CH_DUMP:         it.op = OP_DUMP;
        CH_KILL:         it.op = OP_KILL;
        CH_BS, CH_DEL:   it.op = OP_ERASE;
        CH_CR: begin
          it.op = OP_STORE;
          it.ch = CH_NL;
        end
        default:         it.op = OP_STORE;
      endcase
    end
    return it;
  endfunction

  assign in_tready = !valid_r || q_ready;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (accept) begin
      valid_nxt = 1'b1;
      item_nxt  = classify(in_tuser, in_tdata[7:0], in_tdata[8]);
    end else if (q_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    item_r <= item_nxt;
  end

  assign q_valid = valid_r;
  assign q_item  = item_r;

endmodule

`default_nettype wire

@@ hw/rtl/clep_queue.sv @@
// clep_queue: two-entry fifo of classified items between front and back
// depends on clep_pkg
`default_nettype none

module clep_queue import clep_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push_valid,
  output logic       push_ready,
  input  wire item_t push_item,
  output logic       pop_valid,
  input  wire logic  pop_ready,
  output item_t      pop_item
);

  item_t      slot_r [2];
  logic       wr_r, wr_nxt;
  logic       rd_r, rd_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = slot_r[rd_r];

  always_comb begin
    wr_nxt  = push ? ~wr_r : wr_r;
    rd_nxt  = pop  ? ~rd_r : rd_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      slot_r[wr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/clep_back.sv @@
// clep_back: executes editor operations on the line store and pointers
// depends on clep_pkg and clep_ram
`default_nettype none

module clep_back import clep_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic q_valid,
  output logic      q_ready,
  input  wire item_t q_item,
  output logic      res_valid,
  input  wire logic res_ready,
  output res_t      res
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_KILL_ADDR,
    ST_KILL_CHK
  } state_t;

  state_t           state_r, state_nxt;
  logic [PTR_W-1:0] read_r, read_nxt;
  logic [PTR_W-1:0] commit_r, commit_nxt;
  logic [PTR_W-1:0] edit_r, edit_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             first_r, first_nxt;
  logic             out_valid_r, out_valid_nxt;
  res_t             res_r, res_nxt;

  logic             out_free;
  logic             we;
  logic [ADDR_W-1:0] raddr;
  logic [7:0]       rdata;
  logic [PTR_W-1:0] edit_inc;
  res_t             r0;

  clep_ram #(.WIDTH(8), .DEPTH(BUF_DEPTH)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (ptr_slot(edit_r)),
    .wdata (q_item.ch),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign out_free = !out_valid_r || res_ready;
  assign edit_inc = ptr_inc(edit_r);
  assign raddr    = (state_r == ST_KILL_ADDR) ? ptr_slot(ptr_dec(edit_r))
                                              : ptr_slot(read_r);

  always_comb begin
    state_nxt     = state_r;
    read_nxt      = read_r;
    commit_nxt    = commit_r;
    edit_nxt      = edit_r;
    cnt_nxt       = cnt_r;
    first_nxt     = first_r;
    out_valid_nxt = (out_valid_r && res_ready) ? 1'b0 : out_valid_r;
    res_nxt       = res_r;
    q_ready       = 1'b0;
    we            = 1'b0;
    r0            = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (q_valid && out_free) begin
          q_ready = 1'b1;
          unique case (q_item.op)
            OP_NOP: begin
              res_nxt       = r0;
              out_valid_nxt = 1'b1;
            end
            OP_DUMP: begin
              r0.dump_request = 1'b1;
              res_nxt         = r0;
              out_valid_nxt   = 1'b1;
            end
            OP_ERASE: begin
              if (edit_r != commit_r) begin
                edit_nxt       = ptr_dec(edit_r);
                r0.erase_count = 8'd1;
              end
              res_nxt       = r0;
              out_valid_nxt = 1'b1;
            end
            OP_STORE: begin
              if (ptr_dist(edit_r, read_r) < PTR_DEPTH) begin
                we            = 1'b1;
                edit_nxt      = edit_inc;
                r0.echo_valid = 1'b1;
                r0.echo_char  = q_item.ch;
                if (q_item.ch == CH_NL || q_item.ch == CH_EOF ||
                    ptr_dist(edit_inc, read_r) == PTR_DEPTH) begin
                  commit_nxt    = edit_inc;
                  r0.line_ready = 1'b1;
                end
              end
              res_nxt       = r0;
              out_valid_nxt = 1'b1;
            end
            OP_KILL: begin
              cnt_nxt   = '0;
              state_nxt = ST_KILL_ADDR;
            end
            OP_READ: begin
              if (read_r == commit_r) begin
                r0.read_status = RS_EMPTY;
                res_nxt        = r0;
                out_valid_nxt  = 1'b1;
              end else begin
                first_nxt = q_item.first;
                state_nxt = ST_READ;
              end
            end
            default: begin
              res_nxt       = r0;
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        if (rdata == CH_EOF) begin
          if (first_r) begin
            read_nxt       = ptr_inc(read_r);
            r0.read_status = RS_EOF_TAKEN;
          end else begin
            r0.read_status = RS_EOF_KEPT;
          end
        end else begin
          read_nxt       = ptr_inc(read_r);
          r0.read_status = (rdata == CH_NL) ? RS_NEWLINE : RS_BYTE;
          r0.read_char   = rdata;
        end
        res_nxt       = r0;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      ST_KILL_ADDR: begin
        if (edit_r == commit_r) begin
          r0.erase_count = sat8(cnt_r);
          res_nxt        = r0;
          out_valid_nxt  = 1'b1;
          state_nxt      = ST_IDLE;
        end else begin
          state_nxt = ST_KILL_CHK;
        end
      end
      ST_KILL_CHK: begin
        if (rdata == CH_NL) begin
          r0.erase_count = sat8(cnt_r);
          res_nxt        = r0;
          out_valid_nxt  = 1'b1;
          state_nxt      = ST_IDLE;
        end else begin
          edit_nxt  = ptr_dec(edit_r);
          cnt_nxt   = cnt_r + CNT_W'(1);
          state_nxt = ST_KILL_ADDR;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      read_r      <= '0;
      commit_r    <= '0;
      edit_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      read_r      <= read_nxt;
      commit_r    <= commit_nxt;
      edit_r      <= edit_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cnt_r   <= cnt_nxt;
    first_r <= first_nxt;
    res_r   <= res_nxt;
  end

  assign res_valid = out_valid_r;
  assign res       = res_r;

endmodule

`default_nettype wire

@@ hw/rtl/clep_checker.sv @@
// clep_checker: port-level assertions for console_line_editor, bound to the top
// depends on clep_pkg
`default_nettype none

module clep_checker import clep_pkg::*; (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic [3:0]  out_tuser
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // a read result carries no echo, erase, commit or dump
  a_read_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[3:1] != RS_NONE |->
      !out_tuser[0] && out_tdata[17:0] == 18'd0)
    else $error("read result mixed with edit fields");

  // a plain byte is never NUL, newline or end of file
  a_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[3:1] == RS_BYTE |->
      out_tdata[25:18] != CH_NUL && out_tdata[25:18] != CH_NL &&
      out_tdata[25:18] != CH_EOF)
    else $error("bad byte on plain read");

  // newline status always carries the newline byte
  a_newline: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[3:1] == RS_NEWLINE |-> out_tdata[25:18] == CH_NL)
    else $error("newline status without newline byte");

  // line_ready comes only with an echo and never with an erase
  a_echo: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[16] |-> out_tuser[0] && out_tdata[15:8] == 8'd0)
    else $error("commit without echo");

endmodule

bind console_line_editor clep_checker u_clep_checker (.*);

`default_nettype wire

@@ verif/tb_console_line_editor.sv @@
`timescale 1ns / 100ps
// tb_console_line_editor: self-checking testbench for the console line editor
// depends on clep_pkg and console_line_editor; drives both stream ports with random idling

module tb_console_line_editor;
  import clep_pkg::*;

  // req_type codes carried on in_tuser
  localparam logic REQ_CHAR = 1'b0;
  localparam logic REQ_READ = 1'b1;

  // pointers run modulo twice the ring depth so full and empty differ
  localparam int WRAP = 2 * BUF_DEPTH;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;    // [7:0] rx_char, [8] read_first, rest zero
  logic        in_tuser   = 1'b0;  // [0] req_type
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;          // [7:0] echo_char, [15:8] erase_count,
                                   // [16] line_ready, [17] dump_request,
                                   // [25:18] read_char, rest zero
  logic [3:0]  out_tuser;          // [0] echo_valid, [3:1] read_status

  console_line_editor dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // shadow copy of the editor state, advanced once per accepted item
  logic [7:0]       line_ring [BUF_DEPTH];
  logic [PTR_W-1:0] rd_ptr = '0;
  logic [PTR_W-1:0] cm_ptr = '0;
  logic [PTR_W-1:0] ed_ptr = '0;

  // predicted results, oldest first
  res_t pending_results[$];

  bit idle_on     = 1'b0;  // random gaps and stalls allowed
  int err_cnt     = 0;
  int items_sent  = 0;
  int results_in  = 0;
  int lines_done  = 0;
  int dumps_seen  = 0;
  int max_erase   = 0;
  int status_seen [8];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // pointer arithmetic for the shadow ring
  // ---------------------------------------------------------------------------

  function automatic logic [PTR_W-1:0] ptr_fwd(input logic [PTR_W-1:0] p);
    return PTR_W'((int'(p) + 1) % WRAP);
  endfunction

  function automatic logic [PTR_W-1:0] ptr_back(input logic [PTR_W-1:0] p);
    return PTR_W'((int'(p) + WRAP - 1) % WRAP);
  endfunction

  function automatic int ring_slot(input logic [PTR_W-1:0] p);
    return int'(p) % BUF_DEPTH;
  endfunction

  // number of bytes from b up to a
  function automatic int ring_used(input logic [PTR_W-1:0] a, input logic [PTR_W-1:0] b);
    return (int'(a) + WRAP - int'(b)) % WRAP;
  endfunction

  // ---------------------------------------------------------------------------
  // line discipline predictor: updates the shadow state, returns the result
  // ---------------------------------------------------------------------------

  function automatic res_t predict_line_edit(input logic req, input logic [7:0] rx,
                                             input logic first);
    res_t        r;
    logic [7:0]  c;
    int unsigned erased;
    r      = '0;
    erased = 0;
    c      = rx;
    if (req == REQ_CHAR) begin
      if (rx == CH_DUMP) begin
        r.dump_request = 1'b1;
      end else if (rx == CH_KILL) begin
        // walk back over the uncommitted part, stopping at a newline
        while (ed_ptr != cm_ptr && line_ring[ring_slot(ptr_back(ed_ptr))] != CH_NL) begin
          ed_ptr = ptr_back(ed_ptr);
          erased++;
        end
      end else if (rx == CH_BS || rx == CH_DEL) begin
        if (ed_ptr != cm_ptr) begin
          ed_ptr = ptr_back(ed_ptr);
          erased = 1;
        end
      end else if (rx != CH_NUL && ring_used(ed_ptr, rd_ptr) < BUF_DEPTH) begin
        // carriage return is stored and echoed as newline
        if (rx == CH_CR) c = CH_NL;
        line_ring[ring_slot(ed_ptr)] = c;
        ed_ptr = ptr_fwd(ed_ptr);
        r.echo_valid = 1'b1;
        r.echo_char  = c;
        if (c == CH_NL || c == CH_EOF || ring_used(ed_ptr, rd_ptr) == BUF_DEPTH) begin
          cm_ptr       = ed_ptr;
          r.line_ready = 1'b1;
        end
      end
    end else begin
      if (rd_ptr == cm_ptr) begin
        r.read_status = RS_EMPTY;
      end else begin
        c = line_ring[ring_slot(rd_ptr)];
        if (c == CH_EOF) begin
          // end of file only goes away at the start of a read call
          if (first) begin
            rd_ptr        = ptr_fwd(rd_ptr);
            r.read_status = RS_EOF_TAKEN;
          end else begin
            r.read_status = RS_EOF_KEPT;
          end
        end else begin
          rd_ptr        = ptr_fwd(rd_ptr);
          r.read_status = (c == CH_NL) ? RS_NEWLINE : RS_BYTE;
          r.read_char   = c;
        end
      end
    end
    r.erase_count = (erased > 255) ? 8'hFF : 8'(erased);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  // presents one item, waits for the handshake, then records its prediction
  task automatic send_item(input logic req, input logic [7:0] ch, input logic first);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'b0, first, ch};
    in_tuser  <= req;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(predict_line_edit(req, ch, first));
    items_sent++;
  endtask

  // holds the sender off until every predicted result has been checked
  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // a random byte that the editor simply stores
  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(1, 255));
    end while (c == CH_EOF || c == CH_BS || c == CH_NL || c == CH_CR ||
               c == CH_DUMP || c == CH_KILL || c == CH_DEL);
    return c;
  endfunction

  // one read call: read_first only on its first byte, rx_char is don't-care
  task automatic read_call(input int n);
    int k;
    for (k = 0; k < n; k++) send_item(REQ_READ, 8'($urandom), k == 0);
  endtask

  // typed characters with occasional editing keys mixed in
  task automatic type_line(input int len, input bit with_edits);
    int         k;
    int         pick;
    logic [7:0] ch;
    for (k = 0; k < len; k++) begin
      pick = with_edits ? $urandom_range(0, 39) : 39;
      case (pick) inside
        0, 1: ch = CH_BS;
        2: begin
          ch = CH_DEL;
        end
        3: begin
          ch = CH_KILL;
        end
        4: begin
          ch = CH_DUMP;
        end
        5: begin
          ch = CH_NUL;
        end
        default: begin
          ch = plain_char();
        end
      endcase
      send_item(REQ_CHAR, ch, 1'($urandom));
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // field extremes, each control key but newline, empty and end-of-file reads
  task automatic test_directed_cases();
    send_item(REQ_READ, 8'hFF, 1'b1);    // nothing committed yet
    send_item(REQ_CHAR, CH_NUL, 1'b0);   // ignored
    send_item(REQ_CHAR, CH_DUMP, 1'b1);  // dump request
    send_item(REQ_CHAR, CH_BS, 1'b0);    // erase with nothing typed
    send_item(REQ_CHAR, CH_DEL, 1'b0);
    send_item(REQ_CHAR, CH_KILL, 1'b0);
    send_item(REQ_CHAR, 8'hFF, 1'b0);
    send_item(REQ_CHAR, 8'h01, 1'b1);
    send_item(REQ_CHAR, CH_BS, 1'b1);
    send_item(REQ_CHAR, "a", 1'b0);
    send_item(REQ_CHAR, CH_DEL, 1'b0);
    send_item(REQ_CHAR, "x", 1'b0);
    send_item(REQ_CHAR, "y", 1'b0);
    send_item(REQ_CHAR, CH_KILL, 1'b0);  // line kill takes out y, x and the 0xff
    send_item(REQ_CHAR, "a", 1'b0);
    send_item(REQ_CHAR, "b", 1'b0);
    send_item(REQ_CHAR, CH_EOF, 1'b0);   // commits without newline
    send_item(REQ_CHAR, CH_CR, 1'b0);    // echoed as newline, commits
    send_item(REQ_READ, 8'h00, 1'b1);
    send_item(REQ_READ, 8'h00, 1'b0);
    send_item(REQ_READ, 8'h00, 1'b0);
    send_item(REQ_READ, 8'h00, 1'b0);    // end of file mid call stays put
    send_item(REQ_READ, 8'h00, 1'b1);    // new call consumes it
    send_item(REQ_READ, 8'h00, 1'b1);    // the newline
    send_item(REQ_READ, 8'h00, 1'b1);    // empty again
  endtask

  // fill the ring until it commits itself, then overflow and drain
  task automatic test_ring_full();
    type_line(BUF_DEPTH - ring_used(ed_ptr, rd_ptr), 1'b0);
    send_item(REQ_CHAR, plain_char(), 1'b0);  // dropped, no echo
    send_item(REQ_CHAR, CH_CR, 1'b0);
    send_item(REQ_CHAR, CH_EOF, 1'b1);
    send_item(REQ_CHAR, CH_BS, 1'b0);         // nothing uncommitted
    read_call(ring_used(cm_ptr, rd_ptr) + 1);
  endtask

  // longest possible line kill: one short of a full ring
  task automatic test_long_kill();
    type_line(BUF_DEPTH - 1 - ring_used(ed_ptr, rd_ptr), 1'b0);
    send_item(REQ_CHAR, CH_KILL, 1'b0);
    send_item(REQ_CHAR, CH_KILL, 1'b1);       // nothing left to kill
    type_line(3, 1'b0);
    send_item(REQ_CHAR, CH_NL, 1'b0);
    read_call(ring_used(cm_ptr, rd_ptr) + 1);
  endtask

  // typed lines ended in various ways, read back in calls of random length
  task automatic test_random_sessions(input int quota);
    int start;
    int len;
    int pick;
    int left;
    int n;
    start = items_sent;
    while (items_sent - start < quota) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
      type_line(len, 1'b1);
      pick = $urandom_range(0, 9);
      if (pick <= 3) send_item(REQ_CHAR, CH_CR, 1'($urandom));
      else if (pick <= 6) send_item(REQ_CHAR, CH_NL, 1'($urandom));
      else if (pick <= 8) send_item(REQ_CHAR, CH_EOF, 1'($urandom));
      // sometimes leave the ring alone so it fills up
      if ($urandom_range(0, 4) != 0) begin
        left = ring_used(cm_ptr, rd_ptr) + $urandom_range(0, 2);
        while (left > 0) begin
          n = $urandom_range(1, left);
          read_call(n);
          left -= n;
        end
      end
    end
  endtask

  // unstructured items: any byte, any request, any read_first
  task automatic test_noise(input int count);
    int k;
    for (k = 0; k < count; k++) begin
      send_item(($urandom_range(0, 3) == 0) ? REQ_READ : REQ_CHAR,
                8'($urandom_range(0, 255)), 1'($urandom));
    end
  endtask

  // ---------------------------------------------------------------------------
  // receiver side: random stall bursts and the field by field compare
  // ---------------------------------------------------------------------------

  int stall_left = 0;

  always @(posedge clk) begin : result_monitor
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_in++;
      if (pending_results.size() == 0) begin
        $error("result item with no prediction waiting");
        err_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (out_tuser[0] !== want.echo_valid) begin
          $error("echo_valid: expected %0d, got %0d", want.echo_valid, out_tuser[0]);
          err_cnt++;
        end
        if (out_tdata[7:0] !== want.echo_char) begin
          $error("echo_char: expected %02h, got %02h", want.echo_char, out_tdata[7:0]);
          err_cnt++;
        end
        if (out_tdata[15:8] !== want.erase_count) begin
          $error("erase_count: expected %0d, got %0d", want.erase_count, out_tdata[15:8]);
          err_cnt++;
        end
        if (out_tdata[16] !== want.line_ready) begin
          $error("line_ready: expected %0d, got %0d", want.line_ready, out_tdata[16]);
          err_cnt++;
        end
        if (out_tdata[17] !== want.dump_request) begin
          $error("dump_request: expected %0d, got %0d", want.dump_request, out_tdata[17]);
          err_cnt++;
        end
        if (out_tuser[3:1] !== want.read_status) begin
          $error("read_status: expected %0d, got %0d", want.read_status, out_tuser[3:1]);
          err_cnt++;
        end
        if (out_tdata[25:18] !== want.read_char) begin
          $error("read_char: expected %02h, got %02h", want.read_char, out_tdata[25:18]);
          err_cnt++;
        end
        status_seen[want.read_status]++;
        lines_done += want.line_ready;
        dumps_seen += want.dump_request;
        if (want.erase_count > max_erase) max_erase = want.erase_count;
      end
    end
    // random stall bursts while idling is on
    if (stall_left != 0) stall_left--;
    else if (idle_on && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 5);
    out_tready <= (stall_left == 0);
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    repeat (7) @(posedge clk);
    rst_n   <= 1'b1;
    idle_on  = 1'b1;
    test_directed_cases();
    test_ring_full();
    test_long_kill();
    test_random_sessions(450);
    // sender holds off until everything is back, then a burst with no idling
    wait_for_drain();
    idle_on = 1'b0;
    test_noise(150);
    idle_on = 1'b1;
    test_random_sessions(400);
    // closing stretch without gaps or stalls
    idle_on = 1'b0;
    test_random_sessions(100);
    wait_for_drain();
    repeat (16) @(posedge clk);
    $display("ran %0d items, %0d results: %0d commits, %0d dumps, longest erase %0d",
             items_sent, results_in, lines_done, dumps_seen, max_erase);
    $display("reads: %0d empty, %0d bytes, %0d newlines, %0d eof taken, %0d eof kept",
             status_seen[RS_EMPTY], status_seen[RS_BYTE], status_seen[RS_NEWLINE],
             status_seen[RS_EOF_TAKEN], status_seen[RS_EOF_KEPT]);
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
